// File: src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RERD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define RERD_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/rerd_pkg.sv
// Types and constants of the replay event record deframer.
// No dependencies; used by the decoder, the queue, the top level and the testbench.
package rerd_pkg;

  typedef struct packed {
    logic [7:0]         event_code;
    logic [31:0]        event_time;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [1:0]         record_status;
    logic               last_of_run;
  } rec_t;

  localparam int OQ_DEPTH_DEF = 4;

  localparam logic [1:0] FMT_WINDOW = 2'd1;
  localparam logic [1:0] FMT_GRID   = 2'd2;
  localparam logic [1:0] FMT_RESET  = FMT_GRID;

  localparam logic [1:0] ST_ORDINARY = 2'd0;
  localparam logic [1:0] ST_END      = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  localparam logic [7:0] CODE_MOUSE_LAST  = 8'd7;
  localparam logic [7:0] CODE_ERROR       = 8'd8;
  localparam logic [7:0] CODE_FIRST_CLICK = 8'd2;
  localparam logic [7:0] CODE_BOARD_A_LO  = 8'd9;
  localparam logic [7:0] CODE_BOARD_A_HI  = 8'd14;
  localparam logic [7:0] CODE_END_LAST    = 8'd17;
  localparam logic [7:0] CODE_BOARD_B_LO  = 8'd18;
  localparam logic [7:0] CODE_BOARD_B_HI  = 8'd27;
  localparam logic [7:0] CODE_REDUCED     = 8'd28;

  localparam logic [3:0] MOUSE_BYTES = 4'd8;
  localparam logic [3:0] CELL_BYTES  = 4'd2;

  localparam logic [16:0] X_OFFSET = 17'd12;
  localparam logic [16:0] Y_OFFSET = 17'd56;

  function automatic rec_t mk_rec(logic [7:0] code, logic [31:0] t, logic [16:0] x,
                                  logic [16:0] y, logic [1:0] status, logic last);
    rec_t r;
    r.event_code    = code;
    r.event_time    = t;
    r.pos_x         = x;
    r.pos_y         = y;
    r.record_status = status;
    r.last_of_run   = last;
    return r;
  endfunction

endpackage

// File: src/rerd_if.sv
// Valid/ready channel interfaces of the deframer: byte input and record output.
// Depends on nothing; used by the top level.
interface rerd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rerd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         event_code;
  logic [31:0]        event_time;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic [1:0]         record_status;
  logic               last_of_run;

  modport source (output valid, output event_code, output event_time, output pos_x,
                  output pos_y, output record_status, output last_of_run, input ready);
  modport sink (input valid, input event_code, input event_time, input pos_x,
                input pos_y, input record_status, input last_of_run, output ready);
endinterface

// File: src/rerd_decode.sv
// Byte decoder: parse state, format register, builds up to two records per beat.
// Depends on rerd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rerd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  logic             beat,
  input  logic [7:0]       data_byte,
  output logic [1:0]       push_n,
  output rerd_pkg::rec_t   rec0,
  output rerd_pkg::rec_t   rec1
);

  localparam logic PH_CODE = 1'b0;
  localparam logic PH_BODY = 1'b1;

  logic [1:0]  fmt_r;
  logic        phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [23:0] ts_r, ts_nxt;
  logic [15:0] xs_r, xs_nxt;
  logic [15:0] ys_r, ys_nxt;
  logic        first_r, first_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    logic [16:0] mx;
    logic [16:0] my;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    left_nxt  = left_r;
    ts_nxt    = ts_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    push_n    = 2'd0;
    rec0      = '0;
    rec1      = '0;
    mx        = '0;
    my        = '0;
    if (beat && !done_r) begin
      if (phase_r == PH_CODE) begin
        code_nxt = data_byte;
        if (data_byte <= rerd_pkg::CODE_MOUSE_LAST) begin
          phase_nxt = PH_BODY;
          left_nxt  = rerd_pkg::MOUSE_BYTES;
          ts_nxt    = '0;
          xs_nxt    = '0;
          ys_nxt    = '0;
        end else if (data_byte == rerd_pkg::CODE_ERROR) begin
          rec0     = rerd_pkg::mk_rec(data_byte, '0, '0, '0, rerd_pkg::ST_ERROR, 1'b1);
          push_n   = 2'd1;
          done_nxt = 1'b1;
        end else if ((data_byte inside {[rerd_pkg::CODE_BOARD_A_LO:rerd_pkg::CODE_BOARD_A_HI],
                                        [rerd_pkg::CODE_BOARD_B_LO:rerd_pkg::CODE_BOARD_B_HI]})
                     || (data_byte == rerd_pkg::CODE_REDUCED && fmt_r == rerd_pkg::FMT_GRID))
        begin
          phase_nxt = PH_BODY;
          left_nxt  = rerd_pkg::CELL_BYTES;
          xs_nxt    = '0;
          ys_nxt    = '0;
        end else if (data_byte <= rerd_pkg::CODE_END_LAST) begin
          rec0     = rerd_pkg::mk_rec(data_byte, '0, '0, '0, rerd_pkg::ST_END, 1'b1);
          push_n   = 2'd1;
          done_nxt = 1'b1;
        end else begin
          rec0   = rerd_pkg::mk_rec(data_byte, '0, '0, '0, rerd_pkg::ST_ORDINARY, 1'b1);
          push_n = 2'd1;
        end
      end else if (code_r <= rerd_pkg::CODE_MOUSE_LAST) begin
        if (left_r >= 4'd6) begin
          ts_nxt = {ts_r[15:0], data_byte};
        end else if (left_r == 4'd4 || left_r == 4'd3) begin
          xs_nxt = {xs_r[7:0], data_byte};
        end else if (left_r <= 4'd2) begin
          ys_nxt = {ys_r[7:0], data_byte};
        end
        left_nxt = (left_r != 4'd0) ? left_r - 4'd1 : left_r;
        if (left_nxt == 4'd0) begin
          phase_nxt = PH_CODE;
          mx = {1'b0, xs_nxt};
          my = {1'b0, ys_nxt};
          if (fmt_r == rerd_pkg::FMT_WINDOW) begin
            mx = mx - rerd_pkg::X_OFFSET;
            my = my - rerd_pkg::Y_OFFSET;
          end
          if (first_r) begin
            first_nxt = 1'b0;
            rec0 = rerd_pkg::mk_rec(rerd_pkg::CODE_FIRST_CLICK, {8'd0, ts_nxt}, mx, my,
                                    rerd_pkg::ST_ORDINARY, 1'b0);
            rec1 = rerd_pkg::mk_rec(code_r, {8'd0, ts_nxt}, mx, my,
                                    rerd_pkg::ST_ORDINARY, 1'b1);
            push_n = 2'd2;
          end else begin
            rec0 = rerd_pkg::mk_rec(code_r, {8'd0, ts_nxt}, mx, my,
                                    rerd_pkg::ST_ORDINARY, 1'b1);
            push_n = 2'd1;
          end
        end
      end else if (left_r >= 4'd2) begin
        xs_nxt   = {8'd0, data_byte};
        left_nxt = 4'd1;
      end else begin
        ys_nxt    = {8'd0, data_byte};
        left_nxt  = 4'd0;
        phase_nxt = PH_CODE;
        push_n    = 2'd1;
        if (code_r == rerd_pkg::CODE_REDUCED) begin
          rec0 = rerd_pkg::mk_rec(code_r, prev_r + {24'd0, xs_r[7:0]},
                                  {13'd0, data_byte[7:4]}, {13'd0, data_byte[3:0]},
                                  rerd_pkg::ST_ORDINARY, 1'b1);
        end else begin
          rec0 = rerd_pkg::mk_rec(code_r, '0, {8'd0, {1'b0, xs_r[7:0]} + 9'd1},
                                  {8'd0, {1'b0, data_byte} + 9'd1},
                                  rerd_pkg::ST_ORDINARY, 1'b1);
        end
      end
    end
    prev_nxt = (push_n != 2'd0) ? rec0.event_time : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= rerd_pkg::FMT_RESET;
      phase_r <= PH_CODE;
      code_r  <= '0;
      left_r  <= '0;
      ts_r    <= '0;
      xs_r    <= '0;
      ys_r    <= '0;
      first_r <= 1'b1;
      prev_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      left_r  <= left_nxt;
      ts_r    <= ts_nxt;
      xs_r    <= xs_nxt;
      ys_r    <= ys_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      done_r  <= done_nxt;
    end
  end

  `RERD_ASSERT(a_done_silent, clk, rst_n, done_r |-> push_n == 2'd0, "record after end of stream")
  `RERD_ASSERT(a_pair_once, clk, rst_n, push_n == 2'd2 |=> !first_r, "first click repeated")
  `RERD_NEVER(a_pair_needs_first, clk, rst_n, push_n == 2'd2 && !first_r, "pair without first mouse")

endmodule

// File: src/rerd_outq.sv
// Record queue between decoder and output channel; takes up to two records a beat.
// Depends on rerd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rerd_outq #(
  parameter int DEPTH = rerd_pkg::OQ_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_n,
  input  rerd_pkg::rec_t rec0,
  input  rerd_pkg::rec_t rec1,
  output logic           room,
  output logic           head_valid,
  input  logic           pop,
  output rerd_pkg::rec_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  rerd_pkg::rec_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW-1:0]  wr_p1, wr_p2;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_pop;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign wr_p1      = inc(wr_r);
  assign wr_p2      = inc(wr_p1);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign room       = (cnt_r <= CW'(DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_comb begin
    case (push_n)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = wr_p2;
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = do_pop ? inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push_n) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= rec0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `RERD_NEVER(a_no_overflow, clk, rst_n, push_n != 2'd0 && !room, "push into full queue")
  `RERD_ASSERT(a_cnt_step, clk, rst_n, (push_n == 2'd0 && do_pop) |=> cnt_r == $past(cnt_r) - CW'(1), "count slip")

endmodule

// File: src/replay_event_record_deframer_top.sv
// Top level of the replay event record deframer.
// Depends on rerd_pkg, rerd_if, rerd_decode and rerd_outq.
//
// Takes one byte of a replay event section per cycle and emits decoded
// records one per cycle while the output side takes them. A byte yields zero,
// one or (only for the first mouse event) two records; records wait in a
// queue of OQ_DEPTH entries, and a byte is accepted in any cycle in which
// that queue has room for two more, so with the output side taking records
// every cycle the input runs at one byte per cycle. After an end or error
// record all bytes are taken and dropped until reset. cfg_wr_en writes the
// format register (1 window-relative, 2 grid-relative with reduced moves);
// write it only while no byte is in flight.
module replay_event_record_deframer_top #(
  parameter int OQ_DEPTH = rerd_pkg::OQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  rerd_in_if.sink    in_if,
  rerd_out_if.source out_if
);

  logic           beat;
  logic           room;
  logic [1:0]     push_n;
  rerd_pkg::rec_t rec0, rec1, head;

  assign in_if.ready = room;
  assign beat        = in_if.valid && room;

  rerd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat        (beat),
    .data_byte   (in_if.data_byte),
    .push_n      (push_n),
    .rec0        (rec0),
    .rec1        (rec1)
  );

  rerd_outq #(
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .rec0       (rec0),
    .rec1       (rec1),
    .room       (room),
    .head_valid (out_if.valid),
    .pop        (out_if.ready),
    .head       (head)
  );

  assign out_if.event_code    = head.event_code;
  assign out_if.event_time    = head.event_time;
  assign out_if.pos_x         = head.pos_x;
  assign out_if.pos_y         = head.pos_y;
  assign out_if.record_status = head.record_status;
  assign out_if.last_of_run   = head.last_of_run;

endmodule

// File: test/tb_replay_event_record_deframer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for replay_event_record_deframer_top: byte stream in, records out.
// Depends on rerd_pkg, rerd_if and the deframer RTL; directed table, then random phases.
module tb_replay_event_record_deframer_top;
  import rerd_pkg::*;

  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 60;
  localparam int HOLD_CYCLES = 80;

  localparam logic [1:0] FMT_BARE_0 = 2'd0;
  localparam logic [1:0] FMT_BARE_3 = 2'd3;
  localparam logic [7:0] CODE_END_FIRST  = 8'd15;
  localparam logic [7:0] CODE_EMPTY_LO   = 8'd29;
  localparam logic [7:0] CODE_EMPTY_HI   = 8'd255;

  typedef enum logic {ROW_BYTE, ROW_FMT} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic       typed;
    rec_t       want;
  } row_t;

  localparam rec_t NO_REC = '0;

  localparam row_t PLAN [27] = '{
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 32'd0, 17'd0, 17'd0, ST_ORDINARY, 1'b1}},
    '{ROW_BYTE, 8'h07, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h0E, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b1, '{CODE_BOARD_A_HI, 32'd0, 17'd256, 17'd1, ST_ORDINARY, 1'b1}},
    '{ROW_BYTE, 8'h1C, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hFF, 1'b0, NO_REC},
    '{ROW_BYTE, 8'hA5, 1'b1, '{CODE_REDUCED, 32'd255, 17'd10, 17'd5, ST_ORDINARY, 1'b1}},
    '{ROW_FMT, {6'd0, FMT_WINDOW}, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h1C, 1'b1, '{CODE_REDUCED, 32'd0, 17'd0, 17'd0, ST_ORDINARY, 1'b1}},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b0, NO_REC},
    '{ROW_BYTE, 8'h00, 1'b1, '{8'd0, 32'd0, 17'h1FFF4, 17'h1FFC8, ST_ORDINARY, 1'b1}}
  };

  localparam logic [1:0] FMT_SEQ [PHASES] = '{FMT_GRID, FMT_WINDOW, FMT_BARE_3, FMT_BARE_0,
                                             FMT_WINDOW, FMT_GRID, FMT_GRID, FMT_WINDOW};
  localparam int SEND_IDLE [4]  = '{0, 71, 0, 32};
  localparam int RECV_STALL [4] = '{0, 0, 71, 32};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  rerd_in_if  in_ch ();
  rerd_out_if out_ch ();

  replay_event_record_deframer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // deframer state as predicted
  logic [1:0]  format_reg = FMT_RESET;
  logic        collecting = 1'b0;
  logic [7:0]  cur_code = '0;
  logic [3:0]  bytes_to_go = '0;
  logic [23:0] time_acc = '0;
  logic [15:0] x_acc = '0;
  logic [15:0] y_acc = '0;
  logic        first_click_due = 1'b1;
  logic [31:0] prev_time = '0;
  logic        stream_over = 1'b0;
  rec_t        step_recs [2];

  rec_t records_due [$];
  int   send_pct = 0;
  int   stall_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   errors = 0;
  int   bytes_sent = 0;
  int   records_checked = 0;

  function automatic void keep_rec(int k, logic [7:0] code, logic [31:0] t, logic [16:0] x,
                                   logic [16:0] y, logic [1:0] status, logic last);
    step_recs[k] = '{code, t, x, y, status, last};
    prev_time = t;
  endfunction

  function automatic int deframe_byte(logic [7:0] b);
    logic [16:0] px, py;
    if (stream_over) return 0;
    if (!collecting) begin
      cur_code = b;
      if (b <= CODE_MOUSE_LAST) begin
        collecting = 1'b1;
        bytes_to_go = MOUSE_BYTES;
        time_acc = '0;
        x_acc = '0;
        y_acc = '0;
        return 0;
      end
      if (b == CODE_ERROR) begin
        keep_rec(0, b, '0, '0, '0, ST_ERROR, 1'b1);
        stream_over = 1'b1;
        return 1;
      end
      if ((b >= CODE_BOARD_A_LO && b <= CODE_BOARD_A_HI) ||
          (b >= CODE_BOARD_B_LO && b <= CODE_BOARD_B_HI) ||
          (b == CODE_REDUCED && format_reg == FMT_GRID)) begin
        collecting = 1'b1;
        bytes_to_go = CELL_BYTES;
        x_acc = '0;
        y_acc = '0;
        return 0;
      end
      if (b <= CODE_END_LAST) begin
        keep_rec(0, b, '0, '0, '0, ST_END, 1'b1);
        stream_over = 1'b1;
        return 1;
      end
      keep_rec(0, b, '0, '0, '0, ST_ORDINARY, 1'b1);
      return 1;
    end
    if (cur_code <= CODE_MOUSE_LAST) begin
      if (bytes_to_go >= 4'd6) time_acc = {time_acc[15:0], b};
      else if (bytes_to_go == 4'd4 || bytes_to_go == 4'd3) x_acc = {x_acc[7:0], b};
      else if (bytes_to_go <= 4'd2) y_acc = {y_acc[7:0], b};
      if (bytes_to_go != 0) bytes_to_go--;
      if (bytes_to_go != 0) return 0;
      collecting = 1'b0;
      px = {1'b0, x_acc};
      py = {1'b0, y_acc};
      if (format_reg == FMT_WINDOW) begin
        px = px - X_OFFSET;
        py = py - Y_OFFSET;
      end
      if (first_click_due) begin
        first_click_due = 1'b0;
        keep_rec(0, CODE_FIRST_CLICK, {8'd0, time_acc}, px, py, ST_ORDINARY, 1'b0);
        keep_rec(1, cur_code, {8'd0, time_acc}, px, py, ST_ORDINARY, 1'b1);
        return 2;
      end
      keep_rec(0, cur_code, {8'd0, time_acc}, px, py, ST_ORDINARY, 1'b1);
      return 1;
    end
    if (bytes_to_go >= CELL_BYTES) begin
      x_acc = {8'd0, b};
      bytes_to_go = 4'd1;
      return 0;
    end
    y_acc = {8'd0, b};
    bytes_to_go = '0;
    collecting = 1'b0;
    if (cur_code == CODE_REDUCED) begin
      keep_rec(0, CODE_REDUCED, prev_time + {16'd0, x_acc}, {13'd0, y_acc[7:4]},
               {13'd0, y_acc[3:0]}, ST_ORDINARY, 1'b1);
      return 1;
    end
    keep_rec(0, cur_code, '0, {1'b0, x_acc} + 17'd1, {1'b0, y_acc} + 17'd1, ST_ORDINARY, 1'b1);
    return 1;
  endfunction

  // well-formed records with random payload; never a closing code
  function automatic logic [7:0] draw_byte();
    int r;
    r = $urandom_range(99);
    if (!collecting) begin
      if (r < 25) return 8'($urandom_range(CODE_MOUSE_LAST));
      if (r < 42) return 8'($urandom_range(CODE_BOARD_A_HI, CODE_BOARD_A_LO));
      if (r < 55) return 8'($urandom_range(CODE_BOARD_B_HI, CODE_BOARD_B_LO));
      if (r < 80) return CODE_REDUCED;
      return 8'($urandom_range(CODE_EMPTY_HI, CODE_EMPTY_LO));
    end
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic typed, input rec_t want);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n = deframe_byte(b);
    if (typed) records_due.push_back(want);
    else for (int i = 0; i < n; i++) records_due.push_back(step_recs[i]);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (records_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_format(input logic [1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    format_reg = v;
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_beat
    rec_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.event_code, out_ch.event_time, out_ch.pos_x, out_ch.pos_y,
              out_ch.record_status, out_ch.last_of_run};
      records_checked++;
      if (records_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected record: code %0d time %0d x %0d y %0d st %0d last %0d",
                   got.event_code, got.event_time, got.pos_x, got.pos_y,
                   got.record_status, got.last_of_run);
      end else begin
        want = records_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: code %0d time %0d x %0d y %0d st %0d last %0d",
                     want.event_code, want.event_time, want.pos_x, want.pos_y,
                     want.record_status, want.last_of_run);
            $display("         got: code %0d time %0d x %0d y %0d st %0d last %0d",
                     got.event_code, got.event_time, got.pos_x, got.pos_y,
                     got.record_status, got.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("timeout with %0d records outstanding", records_due.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] close_code;
    int n;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_FMT) write_format(PLAN[i].val[1:0]);
      else push_byte(PLAN[i].val, PLAN[i].typed, PLAN[i].want);
    end

    // receiver blocked while bytes keep coming, so the record queue backs up
    write_format(FMT_GRID);
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    n = 0;
    while (n < 40 || collecting) begin
      push_byte(draw_byte(), 1'b0, NO_REC);
      n++;
    end

    for (int p = 0; p < PHASES; p++) begin
      write_format(FMT_SEQ[p]);
      send_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      n = 0;
      while (n < PHASE_BYTES || collecting) begin
        push_byte(draw_byte(), 1'b0, NO_REC);
        n++;
      end
    end

    n = $urandom_range(3);
    close_code = (n == 0) ? CODE_ERROR : CODE_END_FIRST + 8'(n - 1);
    push_byte(close_code, 1'b0, NO_REC);
    repeat (6) push_byte(8'($urandom_range(255)), 1'b0, NO_REC);

    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d bytes and %0d records over formats 0..3, idle mixes and a %0d-cycle hold",
             bytes_sent, records_checked, HOLD_CYCLES);
    $display("stream closed by code %0d, %0d mismatches", close_code, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
